// ===== hdl/lcmtd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcmtd_pkg
// Shared types and constants for the trial-division LCM block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcmtd_pkg;

  localparam int unsigned MULT_WIDTH = 32;
  localparam int unsigned CAND_START = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_DECIDE,
    ST_DONE
  } lcmtd_state_t;

endpackage

`default_nettype wire

// ===== hdl/lcmtd_divider.sv =====
// ----------------------------------------------------------------------------
// lcmtd_divider
// Shared restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcmtd_divider
  import lcmtd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [OPERAND_WIDTH-1:0] dividend,
  input  wire logic [OPERAND_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [OPERAND_WIDTH-1:0]      quotient,
  output logic [OPERAND_WIDTH-1:0]      remainder
);

  localparam int unsigned CNT_WIDTH = (OPERAND_WIDTH > 2) ? $clog2(OPERAND_WIDTH) : 1;

  logic                     busy;
  logic [CNT_WIDTH-1:0]     count;
  logic [OPERAND_WIDTH-1:0] dvs;
  logic [OPERAND_WIDTH:0]   rem_shift;
  logic [OPERAND_WIDTH:0]   rem_diff;
  logic                     fits;

  assign rem_shift = {remainder, quotient[OPERAND_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs};
  assign fits      = !rem_diff[OPERAND_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
    end else if (busy) begin
      remainder <= fits ? rem_diff[OPERAND_WIDTH-1:0] : rem_shift[OPERAND_WIDTH-1:0];
      quotient  <= {quotient[OPERAND_WIDTH-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcm_trial_division.sv =====
// ----------------------------------------------------------------------------
// lcm_trial_division
// Least common multiple of two unsigned operands by trial division.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and returns one result for it.
// A candidate divisor starts at two; each candidate costs two passes through
// one shared restoring divider, one pass per operand, plus sequencing through
// the check and decide states. The candidate climbs to the largest prime
// factor of either operand. A zero operand goes straight from idle to the
// done state with the invalid flag set and a zero multiple. Results wrap
// modulo 2^32 when the operands are wider than 16 bits.
`default_nettype none

module lcm_trial_division
  import lcmtd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // Fields from bit 0 up: first_value, second_value, zero fill.
  input  wire logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // Fields from bit 0 up: multiple.
  output logic [MULT_WIDTH-1:0]                       m_tdata,
  // Fields from bit 0 up: invalid.
  output logic                                        m_tuser
);

  lcmtd_state_t state, state_next;

  logic [OPERAND_WIDTH-1:0]            val_a;
  logic [OPERAND_WIDTH-1:0]            val_b;
  logic [OPERAND_WIDTH-1:0]            cand;
  logic [MULT_WIDTH-1:0]               mult;
  logic                                inv;
  logic [OPERAND_WIDTH-1:0]            quo_a;
  logic                                hit_a;
  logic                                hit_b;
  logic                                div_start;
  logic                                div_done;
  logic [OPERAND_WIDTH-1:0]            div_dividend;
  logic [OPERAND_WIDTH-1:0]            div_quo;
  logic [OPERAND_WIDTH-1:0]            div_rem;
  logic [MULT_WIDTH+OPERAND_WIDTH-1:0] prod;
  logic [OPERAND_WIDTH-1:0]            in_a;
  logic [OPERAND_WIDTH-1:0]            in_b;
  logic                                out_free;

  assign in_a     = s_tdata[OPERAND_WIDTH-1:0];
  assign in_b     = s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign hit_b    = (div_rem == '0);
  assign prod     = {{OPERAND_WIDTH{1'b0}}, mult} * {{MULT_WIDTH{1'b0}}, cand};
  assign div_dividend = (state == ST_WAIT_A) ? val_b : val_a;

  lcmtd_divider #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cand),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (in_a == '0 || in_b == '0) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (val_a == OPERAND_WIDTH'(1) && val_b == OPERAND_WIDTH'(1)) begin
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_WAIT_A;
        end
      end
      ST_WAIT_A: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        if (div_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        val_a <= in_a;
        val_b <= in_b;
        cand  <= OPERAND_WIDTH'(CAND_START);
        inv   <= (in_a == '0 || in_b == '0);
        mult  <= (in_a == '0 || in_b == '0) ? '0 : MULT_WIDTH'(1);
      end
      ST_WAIT_A: begin
        if (div_done) begin
          quo_a <= div_quo;
          hit_a <= (div_rem == '0);
        end
      end
      ST_DECIDE: begin
        if (hit_a || hit_b) begin
          if (hit_a) begin
            val_a <= quo_a;
          end
          if (hit_b) begin
            val_b <= div_quo;
          end
          mult <= prod[MULT_WIDTH-1:0];
        end else begin
          cand <= cand + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= mult;
      m_tuser <= inv;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcmtd_checker.sv =====
// ----------------------------------------------------------------------------
// lcmtd_checker
// Port-level assertions for the trial-division LCM block.
// ----------------------------------------------------------------------------
`default_nettype none

module lcmtd_checker
  import lcmtd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 s_tvalid,
  input wire logic                                 s_tready,
  input wire logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
  input wire logic                                 m_tvalid,
  input wire logic                                 m_tready,
  input wire logic [MULT_WIDTH-1:0]                m_tdata,
  input wire logic                                 m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Result changed while stalled.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("Invalid result carries a nonzero multiple.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken again right after a transaction.");

  a_zero_operand_flag: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[OPERAND_WIDTH-1:0] == '0 |=>
      ##1 ((m_tvalid && m_tuser) || ($past(m_tvalid, 1) && !$past(m_tready, 1))))
    else $error("Zero operand did not raise the invalid flag.");

endmodule

bind lcm_trial_division lcmtd_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_lcmtd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
